>>> rtl/rhsv_pkg.sv
`timescale 1ns / 1ps

package rhsv_pkg;

    // Hue is carried in 1/64-degree units.
    localparam int unsigned HUE_PER_60 = 3840;
    localparam int unsigned HUE_TURN   = 23040;
    localparam logic [14:0] HUE_OFF_G  = 15'(2 * HUE_PER_60);
    localparam logic [14:0] HUE_OFF_B  = 15'(4 * HUE_PER_60);

    // Quotient widths: hue magnitude stays at or below 3840, saturation below 65536
    // except for the full-saturation case, which is flagged separately.
    localparam int unsigned HQ_W      = 12;
    localparam int unsigned SQ_W      = 16;
    localparam int unsigned DIV_STEPS = SQ_W;

    // Pipeline: input register, analysis, divider set-up, divider steps, output.
    localparam int unsigned NST = 3 + DIV_STEPS + 1;

    localparam logic [1:0] SECT_R = 2'd0;
    localparam logic [1:0] SECT_G = 2'd1;
    localparam logic [1:0] SECT_B = 2'd2;

    typedef struct packed {
        logic [7:0]      hi;
        logic [7:0]      delta;
        logic [8:0]      diff;
        logic [1:0]      sect;
    } t_ana;

    typedef struct packed {
        logic [7:0]      hrem;
        logic [HQ_W-1:0] hnum;
        logic [HQ_W-1:0] hq;
        logic [7:0]      srem;
        logic [SQ_W-1:0] sq;
        logic [7:0]      hi;
        logic [7:0]      delta;
        logic            neg;
        logic [1:0]      sect;
        logic            gray;
        logic            black;
        logic            full;
    } t_div;

    typedef struct packed {
        logic [14:0]     hue;
        logic [16:0]     sat;
        logic [7:0]      val;
    } t_res;

endpackage

>>> rtl/rgb_to_hsv_pixel.sv
`timescale 1ns / 1ps

// Channel   Direction  Width  Contents (lowest bit first)
// s_axis    in         24     blue[7:0], green[15:8], red[23:16]
// m_axis    out        40     hue[14:0], saturation[31:15], value_level[39:32]
//
// One pixel is accepted per clock while the skid register is empty. Between an
// input beat and its output beat lie sixteen one-bit divider stages, which
// produce the saturation quotient (the hue quotient shares the first twelve).
// Reset is synchronous and active low and clears only the valid bits.
// The pipeline advances as a whole; a skid register behind the output stage
// catches the beat that is in flight when the sink stalls, so nothing is lost
// or repeated and the ready seen by the source is a registered signal.

module rgb_to_hsv_pixel
    import rhsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // hue[14:0], saturation[31:15], value_level[39:32]
);

    // One restoring step on each quotient. The hue divider brings down the
    // next numerator bit; the saturation dividend has only zeros below delta.
    function automatic t_div div_step(input t_div s, input logic hue_on);
        t_div       o;
        logic [8:0] th;
        logic [8:0] ts;
        o  = s;
        th = {s.hrem, s.hnum[HQ_W-1]};
        ts = {s.srem, 1'b0};
        if (hue_on) begin
            o.hnum = {s.hnum[HQ_W-2:0], 1'b0};
            if (th >= {1'b0, s.delta}) begin
                o.hrem = 8'(th - {1'b0, s.delta});
                o.hq   = {s.hq[HQ_W-2:0], 1'b1};
            end else begin
                o.hrem = th[7:0];
                o.hq   = {s.hq[HQ_W-2:0], 1'b0};
            end
        end
        if (ts >= {1'b0, s.hi}) begin
            o.srem = 8'(ts - {1'b0, s.hi});
            o.sq   = {s.sq[SQ_W-2:0], 1'b1};
        end else begin
            o.srem = ts[7:0];
            o.sq   = {s.sq[SQ_W-2:0], 1'b0};
        end
        return o;
    endfunction

    logic [NST-1:0] r_vld;
    logic [23:0]    r_pix;
    t_ana           r_ana;
    t_div           r_dv [0:DIV_STEPS];
    t_res           r_out;
    logic           r_skid_v;
    t_res           r_skid;
    logic           w_en;

    // The whole pipeline moves whenever the skid register is empty.
    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    // Stage 1: maximum, minimum and the hue sector. Red wins ties over green,
    // and green over blue.
    t_ana       n_ana;
    logic [7:0] w_b, w_g, w_r, w_lo;

    always_comb begin
        w_b = r_pix[7:0];
        w_g = r_pix[15:8];
        w_r = r_pix[23:16];
        n_ana.hi = (w_r > w_g) ? w_r : w_g;
        if (w_b > n_ana.hi) begin
            n_ana.hi = w_b;
        end
        w_lo = (w_r < w_g) ? w_r : w_g;
        if (w_b < w_lo) begin
            w_lo = w_b;
        end
        n_ana.delta = n_ana.hi - w_lo;
        if (w_r == n_ana.hi) begin
            n_ana.sect = SECT_R;
            n_ana.diff = {1'b0, w_g} - {1'b0, w_b};
        end else if (w_g == n_ana.hi) begin
            n_ana.sect = SECT_G;
            n_ana.diff = {1'b0, w_b} - {1'b0, w_r};
        end else begin
            n_ana.sect = SECT_B;
            n_ana.diff = {1'b0, w_r} - {1'b0, w_g};
        end
    end

    // Stage 2: the hue numerator is 3840 times the magnitude of the channel
    // difference. Since that magnitude never exceeds delta, the top eight bits
    // of the numerator already lie below delta and start the remainder.
    t_div        n_init;
    logic [7:0]  w_mag;
    logic [19:0] w_num;

    always_comb begin
        w_mag        = r_ana.diff[8] ? 8'(-r_ana.diff) : r_ana.diff[7:0];
        w_num        = 20'(w_mag) * 20'(HUE_PER_60);
        n_init.hrem  = w_num[19:12];
        n_init.hnum  = w_num[11:0];
        n_init.hq    = '0;
        n_init.srem  = r_ana.delta;
        n_init.sq    = '0;
        n_init.hi    = r_ana.hi;
        n_init.delta = r_ana.delta;
        n_init.neg   = r_ana.diff[8];
        n_init.sect  = r_ana.sect;
        n_init.gray  = (r_ana.delta == 8'd0);
        n_init.black = (r_ana.hi == 8'd0);
        n_init.full  = (r_ana.delta == r_ana.hi);
    end

    // Final stage: apply the sector offset and the sign, wrap negative hues by
    // a full turn, zero the hue of gray pixels, and pick out the special saturation cases.
    t_res               n_out;
    t_div               w_last;
    logic [14:0]        w_off;
    logic signed [15:0] w_hue;

    always_comb begin
        w_last = r_dv[DIV_STEPS];
        case (w_last.sect)
            SECT_G:  w_off = HUE_OFF_G;
            SECT_B:  w_off = HUE_OFF_B;
            default: w_off = 15'd0;
        endcase
        if (w_last.neg) begin
            w_hue = $signed({1'b0, w_off}) - $signed({4'b0, w_last.hq});
        end else begin
            w_hue = $signed({1'b0, w_off}) + $signed({4'b0, w_last.hq});
        end
        if (w_hue < 0) begin
            w_hue = w_hue + $signed(16'(HUE_TURN));
        end
        n_out.hue = w_last.gray ? 15'd0 : w_hue[14:0];
        if (w_last.black) begin
            n_out.sat = 17'd0;
        end else if (w_last.full) begin
            n_out.sat = 17'h10000;
        end else begin
            n_out.sat = {1'b0, w_last.sq};
        end
        n_out.val = w_last.hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pix    <= s_axis_tdata;
            r_ana    <= n_ana;
            r_dv[0]  <= n_init;
            r_out    <= n_out;
        end
    end

    // Divider steps; the hue quotient needs only the first twelve of them.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[k+1] <= div_step(r_dv[k], (k < HQ_W));
            end
        end
    end

    // Skid register: takes the output beat when the sink refuses it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            r_skid_v <= r_vld[NST-1] && !m_axis_tready;
        end else if (m_axis_tready) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_skid <= r_out;
        end
    end

    assign m_axis_tvalid = r_skid_v || r_vld[NST-1];
    assign m_axis_tdata  = r_skid_v ? {r_skid.val, r_skid.sat, r_skid.hue}
                                    : {r_out.val, r_out.sat, r_out.hue};

endmodule
